// ----- rtl/pfdf_pkg.sv -----
package pfdf_pkg;

   // panel geometry
   localparam int COLUMNS = 128;
   localparam int PAGES   = 8;

   localparam int CELLS  = COLUMNS * PAGES;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;

   // item field widths
   localparam int X_W     = 7;
   localparam int Y_W     = 6;
   localparam int REQ_W   = 16;
   localparam int KIND_W  = 2;
   localparam int BYTE_W  = 8;

   // panel byte constants
   localparam logic [BYTE_W-1:0] PAGE_BASE = 8'hB0;
   localparam logic [BYTE_W-1:0] NIB_MASK  = 8'h0F;
   localparam logic [BYTE_W-1:0] COL_HI    = 8'h10;
   localparam logic [BYTE_W-1:0] MARK_BYTE = 8'h00;

   // input command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_CMD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MARK = 2'd2;

   typedef enum logic [2:0] {
      SEL_PAGE,
      SEL_COL_LO,
      SEL_COL_HI,
      SEL_DATA,
      SEL_MARK
   } rsp_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        clear_step;
      logic        capture;
      logic        pix_rd;
      logic        pix_wr;
      logic        fl_rd;
      logic        shown_wr;
      logic        scan_step;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
      logic        rsp_last;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic pix_ok;
      logic differ;
      logic scan_final;
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- rtl/page_framebuffer_diff_flush.sv -----
// Page-organized monochrome frame buffer with a difference flush. Each byte of the
// frame store holds eight vertical pixels; the byte address is page * COLUMNS + column
// with page = y / 8. A pixel item (command 0) sets or clears one bit and yields no
// result; coordinates outside the panel are dropped. A flush item (command 1) looks at
// the current scan position: if the frame byte differs from the shown copy it yields
// three position command bytes (0xB0 + page, low column nibble, 0x10 | high nibble),
// then the data byte, and updates the shown copy; at the final position a scan-complete
// marker (kind 2, payload 0) follows and the scan wraps to zero. tlast marks the final
// result of an item. Sequence: after reset a clearing pass over all COLUMNS * PAGES
// cells (1024 at 128 x 8) zeroes both stores, with req_tready low. Then one item is in
// work at a time: a pixel item steps through accept, memory read and write back; a
// flush item through accept, memory read and compare, then one result per step, held
// while the output register is full and rsp_tready is low. The output register lets
// the next item be accepted while the last result still waits.
module page_framebuffer_diff_flush (
   input  logic                                clock,
   input  logic                                reset,
   // input item channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pfdf_pkg::REQ_W-1:0]          req_tdata,  // pixel_x, pixel_y, pixel_on, zero
   input  logic                                req_tuser,  // command
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pfdf_pkg::BYTE_W-1:0]         rsp_tdata,  // payload[7:0]
   output logic [pfdf_pkg::KIND_W-1:0]         rsp_tuser,  // kind[1:0]
   output logic                                rsp_tlast
);

   pfdf_pkg::dp_cmd_type    cmd;
   pfdf_pkg::dp_status_type status;

   // sequencer: clearing pass, pixel read-modify-write, flush result stepping
   pfdf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .status      (status),
      .cmd         (cmd)
   );

   // stores, scan position and output register
   pfdf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/pfdf_dp.sv -----
module pfdf_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  pfdf_pkg::dp_cmd_type         cmd,
   output pfdf_pkg::dp_status_type      status,
   input  logic [pfdf_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [pfdf_pkg::BYTE_W-1:0]  rsp_tdata,
   output logic [pfdf_pkg::KIND_W-1:0]  rsp_tuser,
   output logic                         rsp_tlast
);

   localparam int AW = pfdf_pkg::ADDR_W;
   localparam int BW = pfdf_pkg::BYTE_W;

   logic [BW-1:0] frame_mem [pfdf_pkg::CELLS];
   logic [BW-1:0] shown_mem [pfdf_pkg::CELLS];

   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic [pfdf_pkg::X_W-1:0] x_ff;
   logic [pfdf_pkg::Y_W-1:0] y_ff;
   logic                     on_ff;

   logic [AW-1:0]                scan_addr_ff, scan_addr_in;
   logic [pfdf_pkg::COL_W-1:0]   col_ff, col_in;
   logic [pfdf_pkg::PAGE_W-1:0]  page_ff, page_in;

   logic [BW-1:0] frame_q_ff;
   logic [BW-1:0] shown_q_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]                rsp_data_ff, rsp_data_in;
   logic [pfdf_pkg::KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [AW-1:0] pix_addr;
   logic [BW-1:0] pix_mask;
   logic [BW-1:0] pix_byte;
   logic          fr_we;
   logic [AW-1:0] fr_waddr;
   logic [BW-1:0] fr_wdata;
   logic          fr_re;
   logic [AW-1:0] fr_raddr;
   logic          sh_we;
   logic [AW-1:0] sh_waddr;
   logic [BW-1:0] sh_wdata;
   logic          scan_final;
   logic          rsp_free;

   // pixel address: page row times columns plus column
   assign pix_addr = AW'(y_ff >> 3) * AW'(pfdf_pkg::COLUMNS) + AW'(x_ff);
   assign pix_mask = BW'(1) << y_ff[2:0];
   assign pix_byte = on_ff ? (frame_q_ff | pix_mask) : (frame_q_ff & ~pix_mask);

   assign scan_final = (scan_addr_ff == AW'(pfdf_pkg::CELLS - 1));
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign status.clear_last = (clr_addr_ff == AW'(pfdf_pkg::CELLS - 1));
   assign status.pix_ok     = (32'(x_ff) < 32'(pfdf_pkg::COLUMNS))
                           && (32'(y_ff) < 32'(pfdf_pkg::PAGES * 8));
   assign status.differ     = (frame_q_ff != shown_q_ff);
   assign status.scan_final = scan_final;
   assign status.rsp_free   = rsp_free;

   // memory port selection
   always_comb begin
      fr_we    = cmd.clear_step || cmd.pix_wr;
      fr_waddr = cmd.clear_step ? clr_addr_ff : pix_addr;
      fr_wdata = cmd.clear_step ? '0 : pix_byte;
      fr_re    = cmd.pix_rd || cmd.fl_rd;
      fr_raddr = cmd.fl_rd ? scan_addr_ff : pix_addr;
      sh_we    = cmd.clear_step || cmd.shown_wr;
      sh_waddr = cmd.clear_step ? clr_addr_ff : scan_addr_ff;
      sh_wdata = cmd.clear_step ? '0 : frame_q_ff;
   end

   always_ff @(posedge clock) begin
      if (fr_we) begin
         frame_mem[fr_waddr] <= fr_wdata;
      end
      if (fr_re) begin
         frame_q_ff <= frame_mem[fr_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (sh_we) begin
         shown_mem[sh_waddr] <= sh_wdata;
      end
      if (cmd.fl_rd) begin
         shown_q_ff <= shown_mem[scan_addr_ff];
      end
   end

   // captured pixel fields
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff  <= req_tdata[6:0];
         y_ff  <= req_tdata[12:7];
         on_ff <= req_tdata[13];
      end
   end

   // clear counter and scan position
   always_comb begin
      clr_addr_in  = cmd.clear_step ? clr_addr_ff + AW'(1) : clr_addr_ff;
      scan_addr_in = scan_addr_ff;
      col_in       = col_ff;
      page_in      = page_ff;
      if (cmd.scan_step) begin
         scan_addr_in = scan_final ? '0 : scan_addr_ff + AW'(1);
         if (col_ff == pfdf_pkg::COL_W'(pfdf_pkg::COLUMNS - 1)) begin
            col_in  = '0;
            page_in = (page_ff == pfdf_pkg::PAGE_W'(pfdf_pkg::PAGES - 1))
                      ? '0 : page_ff + pfdf_pkg::PAGE_W'(1);
         end else begin
            col_in = col_ff + pfdf_pkg::COL_W'(1);
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.rsp_last;
         case (cmd.rsp_sel)
            pfdf_pkg::SEL_PAGE: begin
               rsp_kind_in = pfdf_pkg::KIND_CMD;
               rsp_data_in = pfdf_pkg::PAGE_BASE + BW'(page_ff);
            end
            pfdf_pkg::SEL_COL_LO: begin
               rsp_kind_in = pfdf_pkg::KIND_CMD;
               rsp_data_in = BW'(col_ff) & pfdf_pkg::NIB_MASK;
            end
            pfdf_pkg::SEL_COL_HI: begin
               rsp_kind_in = pfdf_pkg::KIND_CMD;
               rsp_data_in = pfdf_pkg::COL_HI | BW'(col_ff >> 4);
            end
            pfdf_pkg::SEL_DATA: begin
               rsp_kind_in = pfdf_pkg::KIND_DATA;
               rsp_data_in = frame_q_ff;
            end
            default: begin
               rsp_kind_in = pfdf_pkg::KIND_MARK;
               rsp_data_in = pfdf_pkg::MARK_BYTE;
            end
         endcase
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         scan_addr_ff <= '0;
         col_ff       <= '0;
         page_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         scan_addr_ff <= scan_addr_in;
         col_ff       <= col_in;
         page_ff      <= page_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/pfdf_ctrl.sv -----
module pfdf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_command,
   input  pfdf_pkg::dp_status_type  status,
   output pfdf_pkg::dp_cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_FL_RD,
      ST_FL_CMP,
      ST_FL_EMIT,
      ST_FL_MARK
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] step_ff, step_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.rsp_sel = pfdf_pkg::SEL_MARK;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = (req_command == pfdf_pkg::CMD_FLUSH) ? ST_FL_RD : ST_PIX_RD;
            end
         end
         ST_PIX_RD: begin
            cmd.pix_rd = 1'b1;
            state_in   = ST_PIX_WR;
         end
         ST_PIX_WR: begin
            cmd.pix_wr = status.pix_ok;
            state_in   = ST_IDLE;
         end
         ST_FL_RD: begin
            cmd.fl_rd = 1'b1;
            state_in  = ST_FL_CMP;
         end
         ST_FL_CMP: begin
            step_in = '0;
            if (status.differ) begin
               cmd.shown_wr = 1'b1;
               state_in     = ST_FL_EMIT;
            end else if (status.scan_final) begin
               state_in = ST_FL_MARK;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_FL_EMIT: begin
            cmd.rsp_load = status.rsp_free;
            case (step_ff)
               2'd0:    cmd.rsp_sel = pfdf_pkg::SEL_PAGE;
               2'd1:    cmd.rsp_sel = pfdf_pkg::SEL_COL_LO;
               2'd2:    cmd.rsp_sel = pfdf_pkg::SEL_COL_HI;
               default: cmd.rsp_sel = pfdf_pkg::SEL_DATA;
            endcase
            cmd.rsp_last = (step_ff == 2'd3) && !status.scan_final;
            if (status.rsp_free) begin
               step_in = step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  if (status.scan_final) begin
                     state_in = ST_FL_MARK;
                  end else begin
                     cmd.scan_step = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
            end
         end
         ST_FL_MARK: begin
            cmd.rsp_sel  = pfdf_pkg::SEL_MARK;
            cmd.rsp_last = 1'b1;
            cmd.rsp_load = status.rsp_free;
            if (status.rsp_free) begin
               cmd.scan_step = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule
